FILE: rtl/tpsd_pkg.sv
// Shared types, constants and the phase sequence table for the three-phase
// sensor direction decoder. No dependencies.
`timescale 1ns / 1ps

package tpsd_pkg;

    // default converter sample width
    localparam int SAMPLE_BITS_DEFAULT = 10;

    // sensor channels, one comparator lane each
    localparam int NUM_LANES = 3;

    localparam int PHASE_BITS = 3;
    localparam int DIR_BITS   = 2;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_CH1 = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_CH2 = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_CH3 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HYSTERESIS = 2'd3;

    // register reset values
    localparam int CENTER_RESET     = 425;
    localparam int HYSTERESIS_RESET = 20;

    // direction codes
    localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_DOWN = 2'd2;

    // marks a phase outside the six-step sequence
    localparam logic [PHASE_BITS-1:0] PHASE_NONE = 3'd0;

    typedef logic [PHASE_BITS-1:0] phase_t;

    // one result word
    typedef struct packed {
        logic [DIR_BITS-1:0] direction;
        phase_t              phase_now;
        phase_t              phase_before;
    } tpsd_result_t;

    // forward successor along 4,6,2,3,1,5; PHASE_NONE for 0 and 7
    function automatic phase_t fwd_next(input phase_t phase);
        phase_t nxt;
        begin
            unique case (phase)
                3'd1:    nxt = 3'd5;
                3'd2:    nxt = 3'd3;
                3'd3:    nxt = 3'd1;
                3'd4:    nxt = 3'd6;
                3'd5:    nxt = 3'd4;
                3'd6:    nxt = 3'd2;
                default: nxt = PHASE_NONE;
            endcase
            return nxt;
        end
    endfunction

endpackage

FILE: rtl/tpsd_lane.sv
// One comparator lane: hysteresis threshold for a single sensor channel.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module tpsd_lane #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] center,
    input  logic [SAMPLE_BITS-1:0] hysteresis,
    input  logic                   prev_bit,
    output logic                   phase_bit
);

    // one extra bit so neither side wraps
    logic [SAMPLE_BITS:0] sample_ext;
    logic [SAMPLE_BITS:0] upper;
    logic [SAMPLE_BITS:0] sample_plus_h;
    logic [SAMPLE_BITS:0] center_ext;
    logic                 above;
    logic                 below;

    assign sample_ext    = {1'b0, sample};
    assign center_ext    = {1'b0, center};
    assign upper         = center_ext + {1'b0, hysteresis};
    assign sample_plus_h = sample_ext + {1'b0, hysteresis};

    // s > c + h sets, s < c - h (i.e. s + h < c) clears
    assign above = sample_ext > upper;
    assign below = sample_plus_h < center_ext;

    always_comb
    begin
        phase_bit = prev_bit;
        if (above)
        begin
            phase_bit = 1'b1;
        end
        if (below)
        begin
            phase_bit = 1'b0;
        end
    end

endmodule

FILE: rtl/tpsd_merge.sv
// Merging stage: checks the new phase against the stored one along the
// six-step sequence. Depends on tpsd_pkg.
`timescale 1ns / 1ps

module tpsd_merge (
    input  tpsd_pkg::phase_t       phase_now,
    input  tpsd_pkg::phase_t       phase_before,
    output tpsd_pkg::tpsd_result_t result
);

    import tpsd_pkg::*;

    phase_t succ_before;
    phase_t succ_now;

    assign succ_before = fwd_next(phase_before);
    assign succ_now    = fwd_next(phase_now);

    // forward step wins, then reverse step, else none
    always_comb
    begin
        result.phase_now    = phase_now;
        result.phase_before = phase_before;
        if ((succ_before != PHASE_NONE) && (phase_now == succ_before))
        begin
            result.direction = DIR_UP;
        end
        else if ((succ_now != PHASE_NONE) && (phase_before == succ_now))
        begin
            result.direction = DIR_DOWN;
        end
        else
        begin
            result.direction = DIR_NONE;
        end
    end

endmodule

FILE: rtl/three_phase_sensor_direction_decoder_unit.sv
// An accepted word's result is written to the output register at the accepting clock edge.
// Throughput: one word per cycle unless a full output register is not taken;
// three comparator lanes and the sequence check are combinational on the stored phase.
// Reset: asynchronous, active low; centers return to 425, hysteresis to 20,
// the stored phase to 0, and the output register empties.
`timescale 1ns / 1ps

module three_phase_sensor_direction_decoder_unit #(
    parameter int SAMPLE_BITS = tpsd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [tpsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]          cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [SAMPLE_BITS-1:0]          sample_ch1,
    input  logic [SAMPLE_BITS-1:0]          sample_ch2,
    input  logic [SAMPLE_BITS-1:0]          sample_ch3,
    // output channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tpsd_pkg::DIR_BITS-1:0]   direction,
    output logic [tpsd_pkg::PHASE_BITS-1:0] phase_now,
    output logic [tpsd_pkg::PHASE_BITS-1:0] phase_before
);

    import tpsd_pkg::*;

    logic [SAMPLE_BITS-1:0] center_reg [NUM_LANES];
    logic [SAMPLE_BITS-1:0] hysteresis_reg;
    phase_t                 last_phase_reg;
    phase_t                 phase_next;
    logic [SAMPLE_BITS-1:0] sample_lane [NUM_LANES];
    tpsd_result_t           result_next;
    tpsd_result_t           result_reg;
    logic                   out_valid_reg;
    logic                   in_accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                center_reg[i] <= SAMPLE_BITS'(CENTER_RESET);
            end
            hysteresis_reg <= SAMPLE_BITS'(HYSTERESIS_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTER_CH1: center_reg[0]  <= cfg_data;
                REG_CENTER_CH2: center_reg[1]  <= cfg_data;
                REG_CENTER_CH3: center_reg[2]  <= cfg_data;
                REG_HYSTERESIS: hysteresis_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign sample_lane[0] = sample_ch1;
    assign sample_lane[1] = sample_ch2;
    assign sample_lane[2] = sample_ch3;

    // one comparator lane per channel
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        tpsd_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .sample     (sample_lane[g]),
            .center     (center_reg[g]),
            .hysteresis (hysteresis_reg),
            .prev_bit   (last_phase_reg[g]),
            .phase_bit  (phase_next[g])
        );
    end

    // sequence check on new versus stored phase
    tpsd_merge u_merge (
        .phase_now    (phase_next),
        .phase_before (last_phase_reg),
        .result       (result_next)
    );

    // output register frees up when its word is taken
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // stored phase and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg <= PHASE_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                last_phase_reg <= phase_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign direction    = result_reg.direction;
    assign phase_now    = result_reg.phase_now;
    assign phase_before = result_reg.phase_before;

    // stored phase tracks the phase just reported
    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (last_phase_reg == result_reg.phase_now))
        else $error("stored phase differs from reported phase");

    // a reported step always changes the phase
    a_step_changes_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.direction != DIR_NONE))
            |-> (result_reg.phase_now != result_reg.phase_before))
        else $error("step reported without a phase change");

    // phases outside the sequence never report a step
    a_invalid_phase_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((result_reg.phase_before == 3'd0)
            || (result_reg.phase_before == 3'd7)
            || (result_reg.phase_now == 3'd0)
            || (result_reg.phase_now == 3'd7)))
            |-> (result_reg.direction == DIR_NONE))
        else $error("step reported for an invalid phase");

    // the new word's prior phase is the previous word's phase
    a_phase_chain: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (result_next.phase_before == last_phase_reg))
        else $error("prior phase not taken from stored phase");

endmodule
